[src/lrpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpm_pkg
// Shared widths, generator constants and controller/datapath command types
// for the LCG random pick engine.
// ----------------------------------------------------------------------------
package lrpm_pkg;

    localparam int STATE_W   = 32;
    localparam int MAX_W     = 32;
    localparam int RAND_W    = 31;
    localparam int ADV_STEPS = 3;
    localparam int DIV_STEPS = RAND_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [STATE_W-1:0] LCG_MUL = 32'd1103515245;
    localparam logic [STATE_W-1:0] LCG_INC = 32'd12345;

    // which slice of the raw word an advance fills
    localparam logic [1:0] ADV_LO  = 2'd0;
    localparam logic [1:0] ADV_MID = 2'd1;
    localparam logic [1:0] ADV_HI  = 2'd2;

    typedef struct packed {
        logic       load_max;
        logic       adv;
        logic [1:0] adv_sel;
        logic       div_step;
        logic       out_load;
    } lrpm_cmd_t;

endpackage

[src/lcg_random_pick_modulo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_random_pick_modulo
// Random pick engine: three LCG steps build a 31-bit value, reduced modulo
// the requested maximum (a maximum of zero returns the value as is).
// ----------------------------------------------------------------------------
// One word is taken at a time: it is accepted, the generator steps three
// times through the single 32x32 multiply-add, the radix-2 remainder unit
// runs 31 steps and the output register is loaded, which waits while the
// output is stalled. A new word is taken while the previous result still
// sits in the output register. Writing the seed loads the generator state
// directly; do it only while the block is idle.
module lcg_random_pick_modulo (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           seed_value_we,
    input  logic [lrpm_pkg::STATE_W-1:0]   seed_value_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lrpm_pkg::MAX_W-1:0]     s_value_max,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lrpm_pkg::RAND_W-1:0]    m_random_value
);
    import lrpm_pkg::*;

    lrpm_cmd_t cmd;

    lrpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lrpm_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .seed_value_we    (seed_value_we),
        .seed_value_wdata (seed_value_wdata),
        .s_value_max      (s_value_max),
        .m_random_value   (m_random_value)
    );

endmodule

[src/lrpm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpm_ctrl
// Sequencer: accept a word, step the generator three times, run the
// divider, then load the output register.
// ----------------------------------------------------------------------------
module lrpm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output lrpm_pkg::lrpm_cmd_t cmd
);
    import lrpm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADV  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_max = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_ADV;
                end
            end
            ST_ADV: begin
                cmd.adv     = 1'b1;
                cmd.adv_sel = cnt_reg[1:0];
                if (cnt_reg == CNT_W'(ADV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[src/lrpm_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpm_dp
// Datapath: generator state with its multiply-add, raw word assembly,
// restoring radix-2 remainder unit and output register.
// ----------------------------------------------------------------------------
module lrpm_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lrpm_pkg::lrpm_cmd_t            cmd,
    input  logic                           seed_value_we,
    input  logic [lrpm_pkg::STATE_W-1:0]   seed_value_wdata,
    input  logic [lrpm_pkg::MAX_W-1:0]     s_value_max,
    output logic [lrpm_pkg::RAND_W-1:0]    m_random_value
);
    import lrpm_pkg::*;

    logic [STATE_W-1:0] lcg_reg, lcg_next;
    logic [STATE_W-1:0] lcg_adv;
    logic [MAX_W-1:0]   max_reg;
    logic [RAND_W-1:0]  raw_reg, raw_next;
    logic [RAND_W-1:0]  rem_reg, rem_next;
    logic [RAND_W-1:0]  out_reg;
    logic [RAND_W:0]    rem_sh;
    logic [RAND_W:0]    rem_diff;

    assign lcg_adv = lcg_reg * LCG_MUL + LCG_INC;

    always_comb begin
        lcg_next = lcg_reg;
        if (seed_value_we) begin
            lcg_next = seed_value_wdata;
        end else if (cmd.adv) begin
            lcg_next = lcg_adv;
        end
    end

    // partial remainder never exceeds the partial dividend, so it fits RAND_W bits
    assign rem_sh   = {rem_reg, raw_reg[RAND_W-1]};
    assign rem_diff = rem_sh - max_reg;

    always_comb begin
        raw_next = raw_reg;
        rem_next = rem_reg;
        if (cmd.load_max) begin
            rem_next = '0;
        end
        if (cmd.adv) begin
            case (cmd.adv_sel)
                ADV_LO:  raw_next[9:0]   = lcg_adv[27:18];
                ADV_MID: raw_next[19:10] = lcg_adv[27:18];
                ADV_HI:  raw_next[30:20] = lcg_adv[28:18];
                default: raw_next = raw_reg;
            endcase
        end
        if (cmd.div_step) begin
            raw_next = {raw_reg[RAND_W-2:0], 1'b0};
            if (rem_sh >= max_reg) begin
                rem_next = rem_diff[RAND_W-1:0];
            end else begin
                rem_next = rem_sh[RAND_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lcg_reg <= STATE_W'(1);
        end else begin
            lcg_reg <= lcg_next;
        end
    end

    always_ff @(posedge aclk) begin
        raw_reg <= raw_next;
        rem_reg <= rem_next;
        if (cmd.load_max) begin
            max_reg <= s_value_max;
        end
        if (cmd.out_load) begin
            out_reg <= rem_reg;
        end
    end

    assign m_random_value = out_reg;

endmodule

[src/lrpm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrpm_checker
// Port-level checks for the LCG random pick engine, bound to the top level.
// ----------------------------------------------------------------------------
module lrpm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [lrpm_pkg::RAND_W-1:0]    m_random_value
);
    import lrpm_pkg::*;

    // hold the result word while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_random_value))
        else $error("result word changed while stalled");

    a_busy_next: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after accept");

    a_busy_span: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> ##34 !s_ready)
        else $error("input taken before the remainder could finish");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result shown while still busy");

endmodule

bind lcg_random_pick_modulo lrpm_checker u_checker (.*);

[test/lcg_random_pick_modulo_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_random_pick_modulo_test
// Self-checking bench for the LCG random pick engine. An in-bench generator
// model tracks the 32-bit state, builds each 31-bit pick from three steps and
// reduces it by the requested maximum. Every word taken on the s_ side queues
// one expected pick, and every word on the m_ side is checked against it.
// Directed maxima run first, then random maxima under several seeds, with
// random idling on both sides, the sides swapped, and no idling at all.
// ----------------------------------------------------------------------------

class pick_scoreboard;
    logic [31:0] gen_state;
    logic [30:0] expected_picks[$];
    int          mismatches;
    int          picks_checked;
    int          zero_max_requests;
    int          seeds_loaded;

    function new();
        gen_state = 32'd1;
    endfunction

    function void load_seed(logic [31:0] seed);
        gen_state = seed;
        seeds_loaded++;
    endfunction

    function logic [31:0] lcg_step(logic [31:0] x);
        return x * lrpm_pkg::LCG_MUL + lrpm_pkg::LCG_INC;
    endfunction

    function void note_request(logic [31:0] vmax);
        logic [31:0] s1;
        logic [31:0] s2;
        logic [31:0] s3;
        logic [30:0] raw;
        s1 = lcg_step(gen_state);
        s2 = lcg_step(s1);
        s3 = lcg_step(s2);
        gen_state = s3;
        raw = {s3[28:18], s2[27:18], s1[27:18]};
        if (vmax == 32'd0) begin
            zero_max_requests++;
            expected_picks.push_back(raw);
        end else begin
            expected_picks.push_back(31'({1'b0, raw} % vmax));
        end
    endfunction

    function void check_pick(logic [30:0] actual);
        logic [30:0] want;
        if (expected_picks.size() == 0) begin
            $error("random_value: expected none, actual %0h", actual);
            mismatches++;
            return;
        end
        want = expected_picks.pop_front();
        picks_checked++;
        if (actual !== want) begin
            $error("random_value: expected %0h, actual %0h", want, actual);
            mismatches++;
        end
    endfunction

    function int pending();
        return expected_picks.size();
    endfunction
endclass

module lcg_random_pick_modulo_test;
    import lrpm_pkg::*;

    localparam int CYCLE_LIMIT = 900000;

    localparam logic [31:0] DIRECTED_MAX[16] = '{
        32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
        32'h4000_0000, 32'h0000_03E8, 32'h0000_0000, 32'hAAAA_AAAA,
        32'h5555_5555, 32'h0001_0000, 32'h0000_0007, 32'h0000_0000
    };

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 seed_value_we;
    logic [STATE_W-1:0]   seed_value_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [MAX_W-1:0]     s_value_max;
    logic                 m_valid;
    logic                 m_ready;
    logic [RAND_W-1:0]    m_random_value;

    pick_scoreboard sb;
    int             recv_idle_pct;
    int             cycle_count;

    lcg_random_pick_modulo i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .seed_value_we    (seed_value_we),
        .seed_value_wdata (seed_value_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_value_max      (s_value_max),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_random_value   (m_random_value)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_pick(m_random_value);
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [31:0] random_max();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'($urandom_range(1, 16));
            2: return 32'($urandom_range(17, 65535));
            3: return $urandom >> $urandom_range(0, 31);
            4: return 32'h8000_0000 | $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [31:0] vmax, input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_valid     <= 1'b1;
        s_value_max <= vmax;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(vmax);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        seed_value_we    <= 1'b1;
        seed_value_wdata <= seed;
        @(posedge aclk);
        seed_value_we    <= 1'b0;
        sb.load_seed(seed);
    endtask

    task automatic run_phase(input logic [31:0] seed, input int count,
                             input int send_idle, input int recv_idle);
        write_seed(seed);
        recv_idle_pct = recv_idle;
        for (int k = 0; k < count; k++) begin
            send_word(random_max(), send_idle);
        end
        drain();
    endtask

    initial begin
        sb               = new();
        recv_idle_pct    = 0;
        aresetn          <= 1'b0;
        seed_value_we    <= 1'b0;
        seed_value_wdata <= '0;
        s_valid          <= 1'b0;
        s_value_max      <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset seed first, maxima at the edges
        foreach (DIRECTED_MAX[k]) begin
            send_word(DIRECTED_MAX[k], 0);
        end
        drain();

        // all-zero seed with a few directed maxima
        write_seed(32'h0000_0000);
        for (int k = 0; k < 6; k++) begin
            send_word(DIRECTED_MAX[k], 0);
        end
        drain();

        run_phase(32'h0000_0000, 550, 22, 84);
        run_phase(32'hFFFF_FFFF, 550, 84, 22);
        run_phase($urandom, 275, 0, 0);
        run_phase($urandom, 275, 0, 0);

        repeat (40) @(posedge aclk);

        $display("Checked %0d picks (%0d with a zero maximum) over %0d seed loads,",
                 sb.picks_checked, sb.zero_max_requests, sb.seeds_loaded);
        $display("under sender-heavy, receiver-heavy and back-to-back traffic.");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
